// ----- design/bounding_box_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounding box accumulator
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDING_BOX_ACCUMULATOR_MACROS_SVH
`define BOUNDING_BOX_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every edge
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bounding box accumulator check failed");
// consequent holds in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounding box accumulator check failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Types, constants and helpers shared by the bounding box accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int NAXES       = 3;

  // working coordinate width, held to the field width
  localparam int CW = (COORD_WIDTH < 2) ? 2 : ((COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH);

  typedef logic signed [CW-1:0] coord_t;
  // two guard bits: spans, their sums and differences never overflow
  typedef logic signed [CW+1:0] wide_t;

  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t COORD_ZERO = '0;
  localparam wide_t  WIDE_MAX  = {3'b000, {(CW-1){1'b1}}};
  localparam wide_t  WIDE_MIN  = {3'b111, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_POINT = 2'd1,
    FUNC_BOX   = 2'd2,
    FUNC_NOP   = 2'd3
  } bba_func_t;

  typedef struct packed {
    bba_func_t                 func;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] half_x;
    logic signed [FIELD_W-1:0] half_y;
    logic signed [FIELD_W-1:0] half_z;
  } bba_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic signed [FIELD_W-1:0] center_z;
    logic signed [FIELD_W-1:0] size_x;
    logic signed [FIELD_W-1:0] size_y;
    logic signed [FIELD_W-1:0] size_z;
  } bba_out_t;

  // box after a clear item, as it leaves on the result channel
  localparam bba_out_t BOX_CLEARED = '{
    center_x: '0, center_y: '0, center_z: '0,
    size_x: FIELD_W'(COORD_MIN), size_y: FIELD_W'(COORD_MIN), size_z: FIELD_W'(COORD_MIN)
  };

  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > WIDE_MAX) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/bounding_box_accumulator.sv -----
// ----------------------------------------------------------------------------
// bounding_box_accumulator
// Keeps one 3-D axis-aligned box (center and half-size per axis, Q16.16)
// and merges points or boxes into it, returning the box after each item.
//
// Input channel in_valid/in_stall/in_data carries func and the point or
// other box; each accepted item gives exactly one result on
// out_valid/out_stall/out_data holding the updated box.
// An accepted item lands in the input register; once the result slot is free,
// the three axis units update the box registers, which drive out_data
// directly, and the result is offered from them.
// Throughput is one item per cycle while the receiver does not stall; the
// box registers are updated straight from the input register.
// When the receiver stalls, the result and the box hold; one further item
// waits in the input register, after which in_stall rises.
// Reset empties the box: centers zero, half-sizes most negative, and no
// item or result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounding_box_accumulator_macros.svh"

module bounding_box_accumulator import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bba_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bba_out_t out_data
);

  bba_in_t in_data_r;
  logic    in_vld_r, in_vld_nxt;
  logic    out_vld_r, out_vld_nxt;
  logic    advance;
  logic    in_take;

  coord_t ctr_r  [NAXES];
  coord_t size_r [NAXES];
  coord_t ctr_nxt  [NAXES];
  coord_t size_nxt [NAXES];
  coord_t pos  [NAXES];
  coord_t half [NAXES];

  // item in the input register moves on once the result slot is free
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = in_take || (in_vld_r && !advance);
    out_vld_nxt = advance || (out_vld_r && out_stall);
  end

  always_comb begin
    pos[0]  = in_data_r.pos_x[CW-1:0];
    pos[1]  = in_data_r.pos_y[CW-1:0];
    pos[2]  = in_data_r.pos_z[CW-1:0];
    half[0] = in_data_r.half_x[CW-1:0];
    half[1] = in_data_r.half_y[CW-1:0];
    half[2] = in_data_r.half_z[CW-1:0];
  end

  for (genvar a = 0; a < NAXES; a++) begin : g_axis
    bba_axis u_axis (
      .func     (in_data_r.func),
      .pos      (pos[a]),
      .half     (half[a]),
      .ctr      (ctr_r[a]),
      .size     (size_r[a]),
      .ctr_nxt  (ctr_nxt[a]),
      .size_nxt (size_nxt[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int a = 0; a < NAXES; a++) begin
        ctr_r[a]  <= COORD_ZERO;
        size_r[a] <= COORD_MIN;
      end
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        for (int a = 0; a < NAXES; a++) begin
          ctr_r[a]  <= ctr_nxt[a];
          size_r[a] <= size_nxt[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  assign out_valid = out_vld_r;

  always_comb begin
    out_data.center_x = FIELD_W'(ctr_r[0]);
    out_data.center_y = FIELD_W'(ctr_r[1]);
    out_data.center_z = FIELD_W'(ctr_r[2]);
    out_data.size_x   = FIELD_W'(size_r[0]);
    out_data.size_y   = FIELD_W'(size_r[1]);
    out_data.size_z   = FIELD_W'(size_r[2]);
  end

  // every update offers a result
  `BBA_ASSERT_NEXT(a_adv_result, advance, out_vld_r)
  // box is frozen while a result waits on a stalled receiver
  `BBA_ASSERT_NEXT(a_stall_hold, out_vld_r && out_stall, $stable(out_data))
  // a clear item empties every axis
  `BBA_ASSERT_NEXT(a_clear_empty, advance && in_data_r.func == FUNC_CLEAR, out_data == BOX_CLEARED)
  // unused code leaves the box alone
  `BBA_ASSERT_NEXT(a_nop_hold, advance && in_data_r.func == FUNC_NOP, $stable(out_data))

endmodule

// ----- design/bba_axis.sv -----
// ----------------------------------------------------------------------------
// bba_axis
// Next center and half-size of one axis for a clear, point or box item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_axis import bba_pkg::*; (
  input  bba_func_t func,
  input  coord_t    pos,
  input  coord_t    half,
  input  coord_t    ctr,
  input  coord_t    size,
  output coord_t    ctr_nxt,
  output coord_t    size_nxt
);

  wide_t pw, hw, ow, ew;
  wide_t d, ad, f, nf;
  wide_t lo, hi, sum, mid, hc;
  coord_t span_c, span_e;
  logic pt_inside, box_take, box_keep;

  always_comb begin
    pw = wide_t'(pos);
    hw = wide_t'(half);
    ow = wide_t'(ctr);
    ew = wide_t'(size);

    d  = pw - ow;
    ad = (d < 0) ? -d : d;
    f  = hw - ew;
    nf = -f;

    pt_inside = (ad <= ew);
    box_take  = (ew < 0) || (f >= ad);
    box_keep  = (hw < 0) || (nf >= ad);

    // span ends: the far side of the kept box against the new extreme, or the point alone on an empty box
    if (func == FUNC_POINT) begin
      if (ew < 0) begin
        lo = pw;
        hi = pw;
      end else if (d > 0) begin
        lo = ow - ew;
        hi = pw;
      end else begin
        lo = pw;
        hi = ow + ew;
      end
    end else begin
      if (d > 0) begin
        lo = ow - ew;
        hi = pw + hw;
      end else begin
        lo = pw - hw;
        hi = ow + ew;
      end
    end

    sum    = lo + hi;
    mid    = sum >>> 1;
    span_c = sat_coord(mid);
    hc     = hi - wide_t'(span_c);
    span_e = sat_coord(hc);

    case (func)
      FUNC_CLEAR: begin
        ctr_nxt  = COORD_ZERO;
        size_nxt = COORD_MIN;
      end
      FUNC_POINT: begin
        ctr_nxt  = pt_inside ? ctr  : span_c;
        size_nxt = pt_inside ? size : span_e;
      end
      FUNC_BOX: begin
        if (box_take) begin
          ctr_nxt  = pos;
          size_nxt = half;
        end else if (box_keep) begin
          ctr_nxt  = ctr;
          size_nxt = size;
        end else begin
          ctr_nxt  = span_c;
          size_nxt = span_e;
        end
      end
      default: begin
        ctr_nxt  = ctr;
        size_nxt = size;
      end
    endcase
  end

endmodule
